// ----- rtl/core/fevp_pkg.sv -----
package fevp_pkg;

    // Ring geometry and field widths.
    localparam int ENTRIES   = 64;
    localparam int SIZE_BITS = 40;
    localparam int ID_BITS   = 16;
    localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int SUM_W     = SIZE_BITS + ADDR_W;

    // Input transfer layout, lowest bit first.
    localparam int IN_ACT_LO   = 0;
    localparam int IN_ID_LO    = IN_ACT_LO + 2;
    localparam int IN_SIZE_LO  = IN_ID_LO + ID_BITS;
    localparam int IN_OPEN_LO  = IN_SIZE_LO + SIZE_BITS;
    localparam int IN_EVICT_LO = IN_OPEN_LO + 1;
    localparam int IN_NEED_LO  = IN_EVICT_LO + 1;
    localparam int IN_BITS     = IN_NEED_LO + SIZE_BITS;
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;

    // Result transfer layout, lowest bit first.
    localparam int OUT_ST_LO   = 0;
    localparam int OUT_VV_LO   = OUT_ST_LO + 2;
    localparam int OUT_ID_LO   = OUT_VV_LO + 1;
    localparam int OUT_SIZE_LO = OUT_ID_LO + ID_BITS;
    localparam int OUT_BITS    = OUT_SIZE_LO + SIZE_BITS;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ACT_CREATE     = 2'd0,
        ACT_DELETE     = 2'd1,
        ACT_UPDATE     = 2'd2,
        ACT_MAKE_SPACE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_FULL     = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_EV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_EVICT_RD,
        S_EVICT_EV,
        S_RESULT,
        S_TRIM
    } fevp_state_t;

    // One stored object record.
    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [SIZE_BITS-1:0] size;
        logic                 open;
        logic                 evict;
    } rec_t;

    // Sequencer commands to the shared scan unit.
    typedef struct packed {
        logic clear;
        logic accumulate;
    } scan_ctrl_t;

    // Scan unit verdicts on the record being looked at.
    typedef struct packed {
        logic eligible;
        logic id_hit;
        logic reached;
    } scan_flags_t;

    // Advance a ring pointer with wrap.
    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(ENTRIES - 1)) begin
            r = '0;
        end else begin
            r = p + ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/fevp_slot_ram.sv -----
module fevp_slot_ram
    import fevp_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  rec_t              wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output rec_t              rdata
);

    rec_t mem [ENTRIES];
    rec_t rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/fevp_scan_unit.sv -----
module fevp_scan_unit
    import fevp_pkg::*;
(
    input  logic                 aclk,
    input  scan_ctrl_t           ctrl,
    input  rec_t                 rec,
    input  logic                 slot_valid,
    input  logic [ID_BITS-1:0]   key_id,
    input  logic [SIZE_BITS-1:0] need,
    output scan_flags_t          flags
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    // The one adder and the comparators, shared by the passes over the ring.
    assign sum_next       = sum_reg + SUM_W'(rec.size);
    assign flags.reached  = (sum_next >= SUM_W'(need));
    assign flags.eligible = slot_valid && !rec.open && rec.evict;
    assign flags.id_hit   = slot_valid && (rec.id == key_id);

    // Running total of the sizes of the chosen victims.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            sum_reg <= '0;
        end else if (ctrl.accumulate) begin
            sum_reg <= sum_next;
        end
    end

endmodule

// ----- rtl/core/fifo_evict_with_pinning_core.sv -----
// Sequencing: create goes straight to its result; delete and update read and then test
// each ring slot searched; make space reads and tests each slot scanned, then each slot up to
// the last victim, and then drops the holes at the head one by one.
// Throughput: one item at a time, with a read and a test for each occupied slot visited,
// set by the slot memory's registered read port and the one shared adder and compare.
// Reset: synchronous, active low; the ring is empty afterwards and no clearing pass runs.
module fifo_evict_with_pinning_core
    import fevp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // action, file_id, size_bytes, file_open, evictable, bytes_needed
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, victim_valid, victim_id, victim_size
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    fevp_state_t state_reg, state_next;

    logic [ADDR_W-1:0]    head_reg, tail_reg, p_reg;
    logic [CNT_W-1:0]     used_reg, k_reg, stop_reg;
    logic [ENTRIES-1:0]   valid_reg;

    action_t              act_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 open_reg;
    logic                 evict_reg;
    logic [SIZE_BITS-1:0] need_reg;
    status_t              res_status_reg;

    logic                 m_valid_reg;
    status_t              out_status_reg;
    logic                 out_vv_reg;
    logic [ID_BITS-1:0]   out_id_reg;
    logic [SIZE_BITS-1:0] out_size_reg;
    logic                 out_last_reg;

    action_t              in_action;
    logic [ID_BITS-1:0]   in_id;
    logic [SIZE_BITS-1:0] in_size;
    logic                 in_open;
    logic                 in_evict;
    logic [SIZE_BITS-1:0] in_need;

    logic                 accept;
    logic                 ring_full;
    logic                 out_free;
    logic                 find_end;
    logic                 scan_end;
    logic                 evict_end;
    logic                 evict_last;
    logic                 head_hole;

    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_waddr;
    rec_t                 mem_wdata, mem_rdata;
    scan_ctrl_t           scan_ctrl;
    scan_flags_t          flags;

    logic                 out_load;
    status_t              out_status;
    logic                 out_vv;
    logic [ID_BITS-1:0]   out_id;
    logic [SIZE_BITS-1:0] out_size;
    logic                 out_last;

    // Unpack the input transfer.
    assign in_action = action_t'(s_tdata[IN_ACT_LO +: 2]);
    assign in_id     = s_tdata[IN_ID_LO +: ID_BITS];
    assign in_size   = s_tdata[IN_SIZE_LO +: SIZE_BITS];
    assign in_open   = s_tdata[IN_OPEN_LO];
    assign in_evict  = s_tdata[IN_EVICT_LO];
    assign in_need   = s_tdata[IN_NEED_LO +: SIZE_BITS];

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign ring_full  = (used_reg >= CNT_W'(ENTRIES));
    assign out_free   = !m_valid_reg || m_tready;
    assign find_end   = (k_reg == used_reg);
    assign scan_end   = (k_reg == used_reg);
    assign evict_end  = (k_reg == stop_reg);
    assign evict_last = ((k_reg + CNT_W'(1)) == stop_reg);
    assign head_hole  = (used_reg != '0) && !valid_reg[head_reg];

    fevp_slot_ram u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (p_reg),
        .rdata (mem_rdata)
    );

    fevp_scan_unit u_scan (
        .aclk       (aclk),
        .ctrl       (scan_ctrl),
        .rec        (mem_rdata),
        .slot_valid (valid_reg[p_reg]),
        .key_id     (id_reg),
        .need       (need_reg),
        .flags      (flags)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_action)
                        ACT_CREATE:     state_next = S_RESULT;
                        ACT_DELETE:     state_next = S_FIND_RD;
                        ACT_UPDATE:     state_next = S_FIND_RD;
                        ACT_MAKE_SPACE: state_next = S_SCAN_RD;
                        default:        state_next = S_IDLE;
                    endcase
                end
            end
            S_FIND_RD: state_next = find_end ? S_RESULT : S_FIND_EV;
            S_FIND_EV: state_next = flags.id_hit ? S_RESULT : S_FIND_RD;
            S_SCAN_RD: state_next = scan_end ? S_RESULT : S_SCAN_EV;
            S_SCAN_EV: begin
                state_next = (flags.eligible && flags.reached) ? S_EVICT_RD : S_SCAN_RD;
            end
            S_EVICT_RD: state_next = evict_end ? S_TRIM : S_EVICT_EV;
            S_EVICT_EV: begin
                if (!flags.eligible) begin
                    state_next = S_EVICT_RD;
                end else if (out_free) begin
                    state_next = evict_last ? S_TRIM : S_EVICT_RD;
                end
            end
            S_RESULT: state_next = out_free ? S_TRIM : S_RESULT;
            S_TRIM:   state_next = head_hole ? S_TRIM : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Memory, scan unit and result controls decoded from the state.
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = tail_reg;
        mem_wdata  = '{id: in_id, size: in_size, open: in_open, evict: in_evict};
        mem_re     = 1'b0;
        scan_ctrl  = '{clear: 1'b0, accumulate: 1'b0};
        out_load   = 1'b0;
        out_status = res_status_reg;
        out_vv     = 1'b0;
        out_id     = '0;
        out_size   = '0;
        out_last   = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                mem_we          = accept && (in_action == ACT_CREATE) && !ring_full;
                scan_ctrl.clear = accept;
            end
            S_FIND_RD, S_SCAN_RD: begin
                mem_re = !find_end;
            end
            S_EVICT_RD: begin
                mem_re = !evict_end;
            end
            S_FIND_EV: begin
                mem_we    = flags.id_hit && (act_reg == ACT_UPDATE);
                mem_waddr = p_reg;
                mem_wdata = '{id: id_reg, size: size_reg, open: open_reg, evict: evict_reg};
            end
            S_SCAN_EV: begin
                scan_ctrl.accumulate = flags.eligible;
            end
            S_EVICT_EV: begin
                out_load   = flags.eligible && out_free;
                out_status = ST_OK;
                out_vv     = 1'b1;
                out_id     = mem_rdata.id;
                out_size   = mem_rdata.size;
                out_last   = evict_last;
            end
            S_RESULT: begin
                out_load = out_free;
            end
            S_TRIM: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer, ring bookkeeping and held request fields.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            used_reg  <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        act_reg   <= in_action;
                        id_reg    <= in_id;
                        size_reg  <= in_size;
                        open_reg  <= in_open;
                        evict_reg <= in_evict;
                        need_reg  <= in_need;
                        p_reg     <= head_reg;
                        k_reg     <= '0;
                        if (in_action == ACT_CREATE) begin
                            if (ring_full) begin
                                res_status_reg <= ST_FULL;
                            end else begin
                                res_status_reg      <= ST_OK;
                                valid_reg[tail_reg] <= 1'b1;
                                tail_reg            <= ring_next(tail_reg);
                                used_reg            <= used_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                S_FIND_RD: begin
                    if (find_end) begin
                        res_status_reg <= ST_UNKNOWN;
                    end
                end
                S_FIND_EV: begin
                    if (flags.id_hit) begin
                        res_status_reg <= ST_OK;
                        if (act_reg == ACT_DELETE) begin
                            valid_reg[p_reg] <= 1'b0;
                        end
                    end else begin
                        p_reg <= ring_next(p_reg);
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
                S_SCAN_RD: begin
                    if (scan_end) begin
                        res_status_reg <= (need_reg == '0) ? ST_OK : ST_NO_SPACE;
                    end
                end
                S_SCAN_EV: begin
                    if (flags.eligible && flags.reached) begin
                        stop_reg <= k_reg + CNT_W'(1);
                        p_reg    <= head_reg;
                        k_reg    <= '0;
                    end else begin
                        p_reg <= ring_next(p_reg);
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
                S_EVICT_EV: begin
                    if (!flags.eligible || out_free) begin
                        p_reg <= ring_next(p_reg);
                        k_reg <= k_reg + CNT_W'(1);
                    end
                    if (flags.eligible && out_free) begin
                        valid_reg[p_reg] <= 1'b0;
                    end
                end
                S_TRIM: begin
                    if (head_hole) begin
                        head_reg <= ring_next(head_reg);
                        used_reg <= used_reg - CNT_W'(1);
                    end
                end
                default: begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // Output register: holds a result until the downstream transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= out_status;
            out_vv_reg     <= out_vv;
            out_id_reg     <= out_id;
            out_size_reg   <= out_size;
            out_last_reg   <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_size_reg, out_id_reg, out_vv_reg, out_status_reg});

    // The occupied span never exceeds the ring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(ENTRIES))
    else $error("ring occupancy above capacity");

    // At rest the oldest slot of a non-empty ring holds a live record.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && used_reg != '0) |-> valid_reg[head_reg])
    else $error("hole left at ring head while idle");

    // The eviction pass stays inside the span chosen by the scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVICT_RD) |-> (k_reg <= stop_reg && stop_reg <= used_reg))
    else $error("eviction pass outside scanned span");

    // A victim result is always reported with status ok.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_vv_reg) |-> (out_status_reg == ST_OK))
    else $error("victim reported with error status");

    // A new result is only loaded when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> ($stable(out_id_reg) && $stable(out_last_reg)))
    else $error("stalled result overwritten");

endmodule

// ----- dv/fevp_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the eviction core, keeps its own copy of the
// cache ring and compares every result transfer with the reply it owes.
module fevp_checker
    import fevp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tlast,
    output int               fail_count,
    output int               pending
);

    // One reply the core owes, in the order it must appear.
    typedef struct packed {
        status_t              status;
        logic                 victim;
        logic [ID_BITS-1:0]   id;
        logic [SIZE_BITS-1:0] size;
        logic                 last;
    } cache_reply_t;

    cache_reply_t cache_replies[$];

    // Shadow ring: records in creation order, with holes.
    rec_t cached [ENTRIES];
    logic occupied [ENTRIES];
    int   oldest;
    int   fill_at;
    int   span;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    task automatic owe(input status_t st, input logic victim, input logic [ID_BITS-1:0] id,
                       input logic [SIZE_BITS-1:0] size, input logic last);
        cache_reply_t r;
        r.status = st;
        r.victim = victim;
        r.id     = id;
        r.size   = size;
        r.last   = last;
        cache_replies.insert(cache_replies.size(), r);
    endtask

    function automatic logic may_evict(input int p);
        return occupied[p] && !cached[p].open && cached[p].evict;
    endfunction

    // Holes at the oldest end leave the ring.
    task automatic drop_dead_head();
        while (span > 0 && !occupied[oldest]) begin
            oldest = (oldest + 1) % ENTRIES;
            span = span - 1;
        end
    endtask

    // Applies one accepted request to the shadow ring and queues its replies.
    task automatic cache_request(input logic [IN_W-1:0] word);
        action_t              act;
        logic [ID_BITS-1:0]   id;
        logic [SIZE_BITS-1:0] amount;
        logic [SIZE_BITS-1:0] need;
        logic                 open;
        logic                 ev;
        logic [63:0]          freed;
        logic                 reached;
        int                   p;
        int                   k;
        int                   hit;
        int                   scanned;
        int                   victims;
        int                   emitted;
        act    = action_t'(word[IN_ACT_LO +: 2]);
        id     = word[IN_ID_LO +: ID_BITS];
        amount = word[IN_SIZE_LO +: SIZE_BITS];
        open   = word[IN_OPEN_LO];
        ev     = word[IN_EVICT_LO];
        need   = word[IN_NEED_LO +: SIZE_BITS];
        case (act)
            ACT_CREATE: begin
                drop_dead_head();
                if (span >= ENTRIES) begin
                    owe(ST_FULL, 1'b0, '0, '0, 1'b1);
                end else begin
                    cached[fill_at].id    = id;
                    cached[fill_at].size  = amount;
                    cached[fill_at].open  = open;
                    cached[fill_at].evict = ev;
                    occupied[fill_at] = 1'b1;
                    fill_at = (fill_at + 1) % ENTRIES;
                    span = span + 1;
                    owe(ST_OK, 1'b0, '0, '0, 1'b1);
                end
            end
            ACT_DELETE, ACT_UPDATE: begin
                // Both act on the oldest live record carrying the id.
                hit = -1;
                p = oldest;
                for (k = 0; k < span; k++) begin
                    if (hit < 0 && occupied[p] && cached[p].id == id) begin
                        hit = p;
                    end
                    p = (p + 1) % ENTRIES;
                end
                if (hit < 0) begin
                    owe(ST_UNKNOWN, 1'b0, '0, '0, 1'b1);
                end else begin
                    if (act == ACT_DELETE) begin
                        occupied[hit] = 1'b0;
                        drop_dead_head();
                    end else begin
                        cached[hit].size  = amount;
                        cached[hit].open  = open;
                        cached[hit].evict = ev;
                    end
                    owe(ST_OK, 1'b0, '0, '0, 1'b1);
                end
            end
            default: begin
                // First pass: find how far the victims reach. A zero request
                // still stops at the first eligible record.
                freed = '0;
                scanned = span;
                reached = 1'b0;
                p = oldest;
                for (k = 0; k < span && !reached; k++) begin
                    if (may_evict(p)) begin
                        freed = freed + 64'(cached[p].size);
                        if (freed >= 64'(need)) begin
                            reached = 1'b1;
                            scanned = k + 1;
                        end
                    end
                    p = (p + 1) % ENTRIES;
                end
                if (!reached && need != '0) begin
                    owe(ST_NO_SPACE, 1'b0, '0, '0, 1'b1);
                end else begin
                    victims = 0;
                    p = oldest;
                    for (k = 0; k < scanned; k++) begin
                        if (may_evict(p)) begin
                            victims = victims + 1;
                        end
                        p = (p + 1) % ENTRIES;
                    end
                    if (victims == 0) begin
                        owe(ST_OK, 1'b0, '0, '0, 1'b1);
                    end else begin
                        // Second pass: evict in creation order.
                        emitted = 0;
                        p = oldest;
                        for (k = 0; k < scanned; k++) begin
                            if (may_evict(p)) begin
                                emitted = emitted + 1;
                                owe(ST_OK, 1'b1, cached[p].id, cached[p].size,
                                    emitted == victims);
                                occupied[p] = 1'b0;
                            end
                            p = (p + 1) % ENTRIES;
                        end
                    end
                    drop_dead_head();
                end
            end
        endcase
    endtask

    // Compares one result transfer with the oldest owed reply.
    task automatic check_reply();
        cache_reply_t want;
        if (cache_replies.size() == 0) begin
            report_mismatch("result transfer with no reply owed", 64'(m_tdata), '0);
        end else begin
            want = cache_replies.pop_front();
            if (m_tdata[OUT_ST_LO +: 2] !== want.status) begin
                report_mismatch("status", 64'(m_tdata[OUT_ST_LO +: 2]), 64'(want.status));
            end
            if (m_tdata[OUT_VV_LO] !== want.victim) begin
                report_mismatch("victim_valid", 64'(m_tdata[OUT_VV_LO]), 64'(want.victim));
            end
            if (m_tdata[OUT_ID_LO +: ID_BITS] !== want.id) begin
                report_mismatch("victim_id", 64'(m_tdata[OUT_ID_LO +: ID_BITS]),
                                64'(want.id));
            end
            if (m_tdata[OUT_SIZE_LO +: SIZE_BITS] !== want.size) begin
                report_mismatch("victim_size", 64'(m_tdata[OUT_SIZE_LO +: SIZE_BITS]),
                                64'(want.size));
            end
            if (m_tlast !== want.last) begin
                report_mismatch("last", 64'(m_tlast), 64'(want.last));
            end
        end
    endtask

    // Both channels are sampled at the rising edge, before the core updates.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                occupied[i] = 1'b0;
            end
            oldest = 0;
            fill_at = 0;
            span = 0;
            fail_count = 0;
            cache_replies.delete();
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                cache_request(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_reply();
            end
            pending <= cache_replies.size();
        end
    end

endmodule

// ----- dv/tb_fifo_evict_with_pinning_core.sv -----
`timescale 1ns / 100ps

module tb_fifo_evict_with_pinning_core
    import fevp_pkg::*;
();

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 400;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
    localparam logic [ID_BITS-1:0] ID_MAX = '1;

    // One request as the sender builds it.
    typedef struct packed {
        action_t              act;
        logic [ID_BITS-1:0]   id;
        logic [SIZE_BITS-1:0] size;
        logic                 open;
        logic                 evict;
        logic [SIZE_BITS-1:0] need;
    } cache_cmd_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    int               fail_count;
    int               pending;
    int               idle_cycles;
    int               rx_wait;
    int               rx_draw;
    logic             rx_calm = 1'b0;
    logic             tx_calm = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    fifo_evict_with_pinning_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    fevp_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side: after each transfer, hold off for a randomly drawn wait.
    // Calm stretches take every result at once.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            if ($urandom_range(0, 29) == 0) begin
                rx_calm = !rx_calm;
            end
            rx_draw = rx_calm ? 0 : $urandom_range(0, 11);
            m_tready <= (rx_draw == 0);
            rx_wait <= rx_draw;
        end else if (!m_tready) begin
            if (rx_wait <= 1) begin
                m_tready <= 1'b1;
                rx_wait <= 0;
            end else begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [SIZE_BITS-1:0] wide_rand();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[SIZE_BITS-1:0];
    endfunction

    // Mostly a small pool of ids so that deletes and updates find records.
    function automatic logic [ID_BITS-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            return ID_BITS'($urandom_range(0, 15));
        end else if (roll < 95) begin
            return ID_BITS'($urandom);
        end else begin
            return (roll < 97) ? '0 : ID_MAX;
        end
    endfunction

    function automatic logic [SIZE_BITS-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return SIZE_BITS'($urandom_range(0, 1000));
        end else if (roll < 90) begin
            return wide_rand();
        end else begin
            return (roll < 95) ? '0 : SIZE_MAX;
        end
    endfunction

    function automatic logic [SIZE_BITS-1:0] pick_need();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            return '0;
        end else if (roll < 70) begin
            return SIZE_BITS'($urandom_range(1, 3000));
        end else if (roll < 85) begin
            return wide_rand();
        end else begin
            return SIZE_MAX;
        end
    endfunction

    function automatic cache_cmd_t random_cmd();
        cache_cmd_t c;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            c.act = ACT_CREATE;
        end else if (roll < 55) begin
            c.act = ACT_DELETE;
        end else if (roll < 70) begin
            c.act = ACT_UPDATE;
        end else begin
            c.act = ACT_MAKE_SPACE;
        end
        c.id    = pick_id();
        c.size  = pick_size();
        c.open  = ($urandom_range(0, 3) == 0);
        c.evict = ($urandom_range(0, 4) != 0);
        c.need  = pick_need();
        return c;
    endfunction

    // Sends one request. Valid stays high across back-to-back transfers.
    task automatic send_cmd(input cache_cmd_t c);
        logic [IN_W-1:0] word;
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            tx_calm = !tx_calm;
        end
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[IN_ACT_LO +: 2]          = c.act;
        word[IN_ID_LO +: ID_BITS]     = c.id;
        word[IN_SIZE_LO +: SIZE_BITS] = c.size;
        word[IN_OPEN_LO]              = c.open;
        word[IN_EVICT_LO]             = c.evict;
        word[IN_NEED_LO +: SIZE_BITS] = c.need;
        s_tdata <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Fields that the action ignores keep random values.
    task automatic issue(input action_t act, input logic [ID_BITS-1:0] id,
                         input logic [SIZE_BITS-1:0] amount, input logic open,
                         input logic ev);
        cache_cmd_t c;
        c = random_cmd();
        c.act   = act;
        c.id    = id;
        c.open  = open;
        c.evict = ev;
        if (act == ACT_MAKE_SPACE) begin
            c.need = amount;
        end else begin
            c.size = amount;
        end
        send_cmd(c);
    endtask

    // Holds the sender back until every owed reply has arrived.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty ring, extremes, pinning, duplicates, holes.
        issue(ACT_MAKE_SPACE, 16'd0, '0, 1'b0, 1'b1);
        issue(ACT_DELETE, 16'd5, '0, 1'b0, 1'b1);
        issue(ACT_UPDATE, 16'd5, 40'd9, 1'b0, 1'b1);
        issue(ACT_CREATE, '0, '0, 1'b0, 1'b1);
        issue(ACT_CREATE, ID_MAX, SIZE_MAX, 1'b0, 1'b1);
        issue(ACT_CREATE, 16'd7, 40'd100, 1'b1, 1'b1);
        issue(ACT_CREATE, 16'd7, 40'd200, 1'b0, 1'b0);
        issue(ACT_CREATE, 16'd9, 40'd50, 1'b0, 1'b1);
        issue(ACT_UPDATE, 16'd7, 40'd300, 1'b0, 1'b1);
        issue(ACT_MAKE_SPACE, 16'd0, '0, 1'b0, 1'b0);
        issue(ACT_MAKE_SPACE, 16'd0, SIZE_MAX, 1'b0, 1'b0);
        issue(ACT_MAKE_SPACE, 16'd0, 40'd10000, 1'b0, 1'b0);
        issue(ACT_DELETE, 16'd7, '0, 1'b0, 1'b0);
        issue(ACT_UPDATE, 16'd7, 40'd20, 1'b0, 1'b1);
        issue(ACT_CREATE, 16'd3, 40'd30, 1'b0, 1'b1);
        issue(ACT_DELETE, 16'd9, '0, 1'b0, 1'b0);
        issue(ACT_MAKE_SPACE, 16'd0, 40'd50, 1'b0, 1'b0);
        issue(ACT_CREATE, 16'd1, 40'd5, 1'b1, 1'b0);
        issue(ACT_MAKE_SPACE, 16'd0, 40'd1, 1'b0, 1'b0);
        issue(ACT_MAKE_SPACE, 16'd0, '0, 1'b0, 1'b0);
        issue(ACT_DELETE, 16'd1, '0, 1'b1, 1'b1);

        // The ring is empty now: fill it past capacity, then free it all at once.
        wait_for_replies();
        for (int i = 0; i < 66; i++) begin
            issue(ACT_CREATE, pick_id(), 40'd1, 1'b0, 1'b1);
        end
        issue(ACT_MAKE_SPACE, 16'd0, 40'd64, 1'b0, 1'b0);

        // Random mix, with one more pause in the middle.
        for (int i = 0; i < 342; i++) begin
            if (i == 170) begin
                wait_for_replies();
            end
            send_cmd(random_cmd());
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
